[rtl/core/hsbsca_pkg.sv]
// ============================================================================
// hsbsca_pkg
// Shared types and constants of the selective hue/saturation/brightness unit.
// ============================================================================
package hsbsca_pkg;

    // Register file geometry
    localparam int NUM_BANDS = 7;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int ADJ_W     = 25;

    // Register indexes: master band first, then the six color bands
    typedef enum logic [2:0] {
        REG_MASTER,
        REG_RED,
        REG_YELLOW,
        REG_GREEN,
        REG_CYAN,
        REG_BLUE,
        REG_MAGENTA
    } reg_idx_t;

    // One band's packed deltas, hue in the low bits
    typedef struct packed {
        logic signed [7:0] val;
        logic signed [7:0] sat;
        logic signed [8:0] hue;
    } adj_t;

    typedef adj_t [NUM_BANDS-1:0] adj_bank_t;

endpackage

[rtl/core/hsbsca_cfg.sv]
// ============================================================================
// hsbsca_cfg
// APB register file holding the packed deltas of the master and color bands.
// ============================================================================
module hsbsca_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hsbsca_pkg::ADDR_W-1:0]  paddr,
    input  logic [hsbsca_pkg::DATA_W-1:0]  pwdata,
    output logic [hsbsca_pkg::DATA_W-1:0]  prdata,
    output hsbsca_pkg::adj_bank_t          adj
);
    import hsbsca_pkg::*;

    adj_t       adj_reg [NUM_BANDS];
    logic [2:0] idx;
    logic       idx_ok;
    logic       wr_en;

    // word index, writes beyond the last register are dropped
    assign idx    = paddr[ADDR_W-1:2];
    assign idx_ok = (idx <= REG_MAGENTA);
    assign wr_en  = psel && penable && pwrite && idx_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BANDS; i++)
            begin
                adj_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            adj_reg[idx] <= adj_t'(pwdata[ADJ_W-1:0]);
        end
    end

    // read back, zero-extended
    assign prdata = idx_ok ? DATA_W'(adj_reg[idx]) : '0;

    always_comb
    begin
        for (int i = 0; i < NUM_BANDS; i++)
        begin
            adj[i] = adj_reg[i];
        end
    end

endmodule

[rtl/core/hsb_selective_color_adjust_unit.sv]
// ============================================================================
// hsb_selective_color_adjust_unit
// BGR pixel -> HSB, per-band weighted delta sums, adjust, HSB -> BGR.
// ============================================================================
//  channel  | dir | handshake                | contents
//  s_*      | in  | s_tvalid / s_tready      | one BGR pixel per transfer
//  m_*      | out | m_tvalid / m_tready      | one adjusted pixel per transfer
//  APB      | in  | psel / penable / pready  | seven band delta registers
//
//  One pixel per cycle while m_tready holds high, through a 13-stage
//  pipeline whose divisions use reciprocal tables and constant multipliers.
//  Reset clears the stage valid bits and the delta registers.
//  A stall of m_tready holds the last stage; empty stages upstream keep
//  filling, so s_tready drops only once every stage holds a pixel.
// ============================================================================
module hsb_selective_color_adjust_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // blue_in, green_in, red_in
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // blue_out, green_out, red_out
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hsbsca_pkg::ADDR_W-1:0]  paddr,
    input  logic [hsbsca_pkg::DATA_W-1:0]  pwdata,
    output logic [hsbsca_pkg::DATA_W-1:0]  prdata,
    output logic                           pready
);
    import hsbsca_pkg::*;

    localparam int NSTG = 13;
    localparam logic [28:0] M3000 = 29'(((64'd1 << 40) + 64'd2999) / 64'd3000);
    localparam logic [21:0] Q60   = 22'd3932160;   // 60 * 65536

    typedef enum logic [2:0] {SEC_R, SEC_Y, SEC_G, SEC_C, SEC_B, SEC_M} sector_t;

    adj_bank_t adj;

    hsbsca_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .adj     (adj)
    );

    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // Reciprocal tables: ceil(2^32/d), ceil(2^23/d), ceil(2^36/(30d))
    // ------------------------------------------------------------------
    logic [32:0] rcp_s [256];
    logic [23:0] rcp_h [256];
    logic [31:0] rcp_d [256];

    for (genvar gi = 0; gi < 256; gi++)
    begin : g_rcp
        localparam longint unsigned DV = (gi == 0) ? 64'd1 : 64'(gi);
        localparam logic [32:0] RS = 33'(((64'd1 << 32) + DV - 64'd1) / DV);
        localparam logic [23:0] RH = 24'(((64'd1 << 23) + DV - 64'd1) / DV);
        localparam logic [31:0] RD =
            32'(((64'd1 << 36) + 64'd30 * DV - 64'd1) / (64'd30 * DV));
        assign rcp_s[gi] = RS;
        assign rcp_h[gi] = RH;
        assign rcp_d[gi] = RD;
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when empty or when the next one moves
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NSTG-1];

    // ------------------------------------------------------------------
    // Stage 0: max, min, hue sector offset, brightness
    // ------------------------------------------------------------------
    logic [7:0]        b_in, g_in, r_in, mx_next, mn_next, rr_next;
    logic signed [8:0] diff_next;
    logic [8:0]        off_next;
    logic [7:0]        s0_mx_reg, s0_rr_reg, s0_rng_reg;
    logic signed [8:0] s0_diff_reg;
    logic [8:0]        s0_off_reg;
    logic [16:0]       s0_v_reg;

    assign b_in = s_tdata[7:0];
    assign g_in = s_tdata[15:8];
    assign r_in = s_tdata[23:16];

    always_comb
    begin
        mx_next = b_in;
        mn_next = b_in;
        if (g_in > mx_next) mx_next = g_in;
        if (r_in > mx_next) mx_next = r_in;
        if (g_in < mn_next) mn_next = g_in;
        if (r_in < mn_next) mn_next = r_in;
        rr_next   = mx_next - mn_next;
        diff_next = '0;
        off_next  = '0;
        // grey pixel keeps hue 0
        if (rr_next != 8'd0)
        begin
            if (mx_next == r_in)
            begin
                diff_next = $signed({1'b0, g_in}) - $signed({1'b0, b_in});
                off_next  = (g_in >= b_in) ? 9'd0 : 9'd360;
            end
            else if (mx_next == g_in)
            begin
                diff_next = $signed({1'b0, b_in}) - $signed({1'b0, r_in});
                off_next  = 9'd120;
            end
            else
            begin
                diff_next = $signed({1'b0, r_in}) - $signed({1'b0, g_in});
                off_next  = 9'd240;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_mx_reg   <= mx_next;
            s0_rr_reg   <= rr_next;
            s0_rng_reg  <= (rr_next == 8'd0) ? 8'd1 : rr_next;
            s0_diff_reg <= diff_next;
            s0_off_reg  <= off_next;
            // max*65536/255 = max*257 + (max == 255)
            s0_v_reg    <= 17'(mx_next) * 17'd257 + 17'(mx_next == 8'd255);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: reciprocal lookups, hue numerator magnitude
    // ------------------------------------------------------------------
    logic [7:0]        mag;
    logic [13:0]       mag60;
    logic [32:0]       s1_ms_reg;
    logic [23:0]       s1_mh_reg;
    logic [31:0]       s1_md_reg;
    logic [14:0]       s1_ah_reg;
    logic              s1_neg_reg;
    logic [7:0]        s1_rr_reg, s1_rng_reg;
    logic [8:0]        s1_off_reg;
    logic signed [8:0] s1_diff_reg;
    logic [16:0]       s1_v_reg;

    assign mag   = s0_diff_reg[8] ? 8'(-s0_diff_reg) : 8'(s0_diff_reg);
    assign mag60 = (14'(mag) << 6) - (14'(mag) << 2);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_ms_reg   <= rcp_s[s0_mx_reg];
            s1_mh_reg   <= rcp_h[s0_rng_reg];
            s1_md_reg   <= rcp_d[s0_rng_reg];
            // ceiling for a negative numerator
            s1_ah_reg   <= 15'(mag60) + (s0_diff_reg[8] ? 15'(s0_rng_reg - 8'd1) : 15'd0);
            s1_neg_reg  <= s0_diff_reg[8];
            s1_rr_reg   <= s0_rr_reg;
            s1_rng_reg  <= s0_rng_reg;
            s1_off_reg  <= s0_off_reg;
            s1_diff_reg <= s0_diff_reg;
            s1_v_reg    <= s0_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: saturation and coarse hue quotients
    // ------------------------------------------------------------------
    logic [40:0]       ps;
    logic [38:0]       ph;
    logic [16:0]       s2_s_reg, s2_v_reg;
    logic [6:0]        s2_qh_reg;
    logic              s2_neg_reg;
    logic [7:0]        s2_rng_reg;
    logic [8:0]        s2_off_reg;
    logic signed [8:0] s2_diff_reg;
    logic [31:0]       s2_md_reg;

    assign ps = 41'(s1_rr_reg) * 41'(s1_ms_reg);
    assign ph = 39'(s1_ah_reg) * 39'(s1_mh_reg);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_s_reg    <= ps[32:16];
            s2_qh_reg   <= ph[29:23];
            s2_neg_reg  <= s1_neg_reg;
            s2_rng_reg  <= s1_rng_reg;
            s2_off_reg  <= s1_off_reg;
            s2_diff_reg <= s1_diff_reg;
            s2_md_reg   <= s1_md_reg;
            s2_v_reg    <= s1_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: whole-degree hue, band weights
    // ------------------------------------------------------------------
    logic [8:0]        h_int;
    logic [9:0]        tw [1:NUM_BANDS-1];
    logic [7:0]        hdist [1:NUM_BANDS-1];
    logic [4:0]        w_next [1:NUM_BANDS-1];
    logic [4:0]        s3_w_reg [1:NUM_BANDS-1];
    logic [16:0]       s3_p0_reg;
    logic signed [8:0] s3_diff_reg;
    logic [7:0]        s3_rng_reg;
    logic [31:0]       s3_md_reg;
    logic [16:0]       s3_s_reg, s3_v_reg;

    assign h_int = s2_neg_reg ? (s2_off_reg - 9'(s2_qh_reg)) : (s2_off_reg + 9'(s2_qh_reg));

    always_comb
    begin
        for (int k = 1; k < NUM_BANDS; k++)
        begin
            tw[k] = 10'(h_int) + 10'd540 - 10'((k - 1) * 60);
            if (tw[k] >= 10'd720)
                tw[k] = tw[k] - 10'd720;
            else if (tw[k] >= 10'd360)
                tw[k] = tw[k] - 10'd360;
            hdist[k] = (tw[k] >= 10'd180) ? 8'(tw[k] - 10'd180) : 8'(10'd180 - tw[k]);
            if (hdist[k] <= 8'd15)
                w_next[k] = 5'd30;
            else if (hdist[k] <= 8'd45)
                w_next[k] = 5'(8'd45 - hdist[k]);
            else
                w_next[k] = 5'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_w_reg    <= w_next;
            s3_p0_reg   <= 17'(s2_off_reg) * 17'(s2_rng_reg);
            s3_diff_reg <= s2_diff_reg;
            s3_rng_reg  <= s2_rng_reg;
            s3_md_reg   <= s2_md_reg;
            s3_s_reg    <= s2_s_reg;
            s3_v_reg    <= s2_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: weighted delta sums in thirtieths
    // ------------------------------------------------------------------
    logic signed [15:0] hacc, sacc, vacc, wk;
    logic signed [15:0] s4_hsum_reg, s4_ssum_reg, s4_vsum_reg;
    logic [16:0]        s4_p0_reg;
    logic signed [8:0]  s4_diff_reg;
    logic [7:0]         s4_rng_reg;
    logic [31:0]        s4_md_reg;
    logic [16:0]        s4_s_reg, s4_v_reg;

    always_comb
    begin
        hacc = 16'(adj[REG_MASTER].hue) * 16'sd30;
        sacc = 16'(adj[REG_MASTER].sat) * 16'sd30;
        vacc = 16'(adj[REG_MASTER].val) * 16'sd30;
        wk   = '0;
        for (int k = 1; k < NUM_BANDS; k++)
        begin
            wk   = $signed({11'd0, s3_w_reg[k]});
            hacc = hacc + 16'(adj[k].hue) * wk;
            sacc = sacc + 16'(adj[k].sat) * wk;
            vacc = vacc + 16'(adj[k].val) * wk;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_hsum_reg <= hacc;
            s4_ssum_reg <= sacc;
            s4_vsum_reg <= vacc;
            s4_p0_reg   <= s3_p0_reg;
            s4_diff_reg <= s3_diff_reg;
            s4_rng_reg  <= s3_rng_reg;
            s4_md_reg   <= s3_md_reg;
            s4_s_reg    <= s3_s_reg;
            s4_v_reg    <= s3_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: hue numerator, clip saturation/brightness sums
    // ------------------------------------------------------------------
    logic signed [23:0] x_next;
    logic signed [12:0] sc_next, vc_next;
    logic signed [23:0] s5_x_reg;
    logic signed [12:0] s5_sc_reg, s5_vc_reg;
    logic [31:0]        s5_md_reg;
    logic [16:0]        s5_s_reg, s5_v_reg;

    assign x_next = $signed({7'd0, s4_p0_reg}) * 24'sd30
                  + 24'(s4_diff_reg) * 24'sd1800
                  + 24'(s4_hsum_reg) * $signed({16'd0, s4_rng_reg});

    always_comb
    begin
        if (s4_ssum_reg < -16'sd3000)
            sc_next = -13'sd3000;
        else if (s4_ssum_reg > 16'sd3000)
            sc_next = 13'sd3000;
        else
            sc_next = 13'(s4_ssum_reg);
        if (s4_vsum_reg < -16'sd3000)
            vc_next = -13'sd3000;
        else if (s4_vsum_reg > 16'sd3000)
            vc_next = 13'sd3000;
        else
            vc_next = 13'(s4_vsum_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_x_reg  <= x_next;
            s5_sc_reg <= sc_next;
            s5_vc_reg <= vc_next;
            s5_md_reg <= s4_md_reg;
            s5_s_reg  <= s4_s_reg;
            s5_v_reg  <= s4_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: hue quotient, saturation step products
    // ------------------------------------------------------------------
    logic [22:0]        ax;
    logic [54:0]        pq;
    logic               sneg;
    logic [11:0]        fs;
    logic [16:0]        sbase;
    logic [9:0]         s6_q_reg;
    logic               s6_xneg_reg, s6_sneg_reg;
    logic [27:0]        s6_as_reg, s6_av_reg;
    logic [16:0]        s6_s_reg, s6_v_reg;
    logic signed [12:0] s6_vc_reg;

    assign ax    = s5_x_reg[23] ? 23'(-s5_x_reg) : 23'(s5_x_reg);
    assign pq    = 55'(ax) * 55'(s5_md_reg);
    assign sneg  = s5_sc_reg[12];
    assign fs    = sneg ? 12'(13'sd3000 + s5_sc_reg) : 12'(s5_sc_reg);
    assign sbase = sneg ? s5_s_reg : 17'(18'd65536 - 18'(s5_s_reg));

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_q_reg    <= pq[45:36];
            s6_xneg_reg <= s5_x_reg[23];
            s6_sneg_reg <= sneg;
            s6_as_reg   <= 28'(29'(sbase) * 29'(fs));
            s6_av_reg   <= 28'(29'(17'(18'd65536 - 18'(s5_v_reg))) * 29'(fs));
            s6_s_reg    <= s5_s_reg;
            s6_v_reg    <= s5_v_reg;
            s6_vc_reg   <= s5_vc_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: hue modulo 360, saturation step divide by 3000
    // ------------------------------------------------------------------
    logic signed [10:0] hq, hm;
    logic [56:0]        dsp, dvp;
    logic [16:0]        ds1, dv1;
    logic [8:0]         s7_hue_reg;
    logic [16:0]        s7_s_reg, s7_v_reg;
    logic signed [12:0] s7_vc_reg;

    assign hq  = s6_xneg_reg ? -$signed({1'b0, s6_q_reg}) : $signed({1'b0, s6_q_reg});
    assign dsp = 57'(s6_as_reg) * 57'(M3000);
    assign dvp = 57'(s6_av_reg) * 57'(M3000);
    assign ds1 = dsp[56:40];
    assign dv1 = dvp[56:40];

    always_comb
    begin
        if (hq < -11'sd360)
            hm = hq + 11'sd720;
        else if (hq < 11'sd0)
            hm = hq + 11'sd360;
        else if (hq >= 11'sd720)
            hm = hq - 11'sd720;
        else if (hq >= 11'sd360)
            hm = hq - 11'sd360;
        else
            hm = hq;
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_hue_reg <= 9'(hm);
            s7_s_reg   <= s6_sneg_reg ? ds1 : 17'(s6_s_reg + ds1);
            s7_v_reg   <= s6_sneg_reg ? s6_v_reg : 17'(s6_v_reg + dv1);
            s7_vc_reg  <= s6_vc_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: hue sector, brightness step products
    // ------------------------------------------------------------------
    sector_t     sec_next;
    logic [8:0]  sec_base;
    logic        vneg;
    logic [11:0] fb;
    logic [16:0] vbase;
    sector_t     s8_sec_reg;
    logic [5:0]  s8_rem_reg;
    logic [27:0] s8_as_reg, s8_av_reg;
    logic        s8_vneg_reg;
    logic [16:0] s8_s_reg, s8_v_reg;

    always_comb
    begin
        if (s7_hue_reg >= 9'd300)
        begin
            sec_next = SEC_M;
            sec_base = 9'd300;
        end
        else if (s7_hue_reg >= 9'd240)
        begin
            sec_next = SEC_B;
            sec_base = 9'd240;
        end
        else if (s7_hue_reg >= 9'd180)
        begin
            sec_next = SEC_C;
            sec_base = 9'd180;
        end
        else if (s7_hue_reg >= 9'd120)
        begin
            sec_next = SEC_G;
            sec_base = 9'd120;
        end
        else if (s7_hue_reg >= 9'd60)
        begin
            sec_next = SEC_Y;
            sec_base = 9'd60;
        end
        else
        begin
            sec_next = SEC_R;
            sec_base = 9'd0;
        end
    end

    assign vneg  = s7_vc_reg[12];
    assign fb    = vneg ? 12'(13'sd3000 + s7_vc_reg) : 12'(s7_vc_reg);
    assign vbase = vneg ? s7_v_reg : 17'(18'd65536 - 18'(s7_v_reg));

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s8_sec_reg  <= sec_next;
            s8_rem_reg  <= 6'(s7_hue_reg - sec_base);
            s8_av_reg   <= 28'(29'(vbase) * 29'(fb));
            s8_as_reg   <= 28'(29'(s7_s_reg) * 29'(fb));
            s8_vneg_reg <= vneg;
            s8_s_reg    <= s7_s_reg;
            s8_v_reg    <= s7_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: brightness step divide by 3000
    // ------------------------------------------------------------------
    logic [56:0] dvp2, dsp2;
    logic [16:0] dv2, ds2;
    sector_t     s9_sec_reg;
    logic [5:0]  s9_rem_reg;
    logic [16:0] s9_s_reg, s9_v_reg;

    assign dvp2 = 57'(s8_av_reg) * 57'(M3000);
    assign dsp2 = 57'(s8_as_reg) * 57'(M3000);
    assign dv2  = dvp2[56:40];
    assign ds2  = dsp2[56:40];

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            s9_sec_reg <= s8_sec_reg;
            s9_rem_reg <= s8_rem_reg;
            s9_v_reg   <= s8_vneg_reg ? dv2 : 17'(s8_v_reg + dv2);
            s9_s_reg   <= s8_vneg_reg ? s8_s_reg : 17'(s8_s_reg - ds2);
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: rS, (60-r)S, V(1-S), brightness byte
    // ------------------------------------------------------------------
    logic [24:0] v255;
    logic [22:0] s10_rs_reg, s10_ts_reg;
    logic [33:0] s10_pp_reg;
    logic [7:0]  s10_vb_reg;
    sector_t     s10_sec_reg;
    logic [16:0] s10_v_reg;

    assign v255 = (25'(s9_v_reg) << 8) - 25'(s9_v_reg);

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            s10_rs_reg  <= 23'(s9_rem_reg) * 23'(s9_s_reg);
            s10_ts_reg  <= 23'(6'd60 - s9_rem_reg) * 23'(s9_s_reg);
            s10_pp_reg  <= 34'(s9_v_reg) * 34'(17'(18'd65536 - 18'(s9_s_reg)));
            s10_vb_reg  <= v255[23:16];
            s10_sec_reg <= s9_sec_reg;
            s10_v_reg   <= s9_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: q and t products, p byte
    // ------------------------------------------------------------------
    logic [41:0] pp255;
    logic [38:0] s11_xq_reg, s11_xt_reg;
    logic [7:0]  s11_pb_reg, s11_vb_reg;
    sector_t     s11_sec_reg;

    assign pp255 = (42'(s10_pp_reg) << 8) - 42'(s10_pp_reg);

    always_ff @(posedge clk)
    begin
        if (en[11])
        begin
            s11_xq_reg  <= 39'(s10_v_reg) * 39'(22'(23'(Q60) - s10_rs_reg));
            s11_xt_reg  <= 39'(s10_v_reg) * 39'(22'(23'(Q60) - s10_ts_reg));
            s11_pb_reg  <= pp255[39:32];
            s11_vb_reg  <= s10_vb_reg;
            s11_sec_reg <= s10_sec_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 12: q/t bytes (x*255/60 = x*17/4), sector select, output
    // ------------------------------------------------------------------
    logic [42:0] xq17, xt17;
    logic [7:0]  qb, tb;
    logic [7:0]  ob_next, og_next, or_next;
    logic [7:0]  s12_b_reg, s12_g_reg, s12_r_reg;

    assign xq17 = (43'(s11_xq_reg) << 4) + 43'(s11_xq_reg);
    assign xt17 = (43'(s11_xt_reg) << 4) + 43'(s11_xt_reg);
    assign qb   = xq17[41:34];
    assign tb   = xt17[41:34];

    always_comb
    begin
        case (s11_sec_reg)
            SEC_R:
            begin
                or_next = s11_vb_reg; og_next = tb;         ob_next = s11_pb_reg;
            end
            SEC_Y:
            begin
                or_next = qb;         og_next = s11_vb_reg; ob_next = s11_pb_reg;
            end
            SEC_G:
            begin
                or_next = s11_pb_reg; og_next = s11_vb_reg; ob_next = tb;
            end
            SEC_C:
            begin
                or_next = s11_pb_reg; og_next = qb;         ob_next = s11_vb_reg;
            end
            SEC_B:
            begin
                or_next = tb;         og_next = s11_pb_reg; ob_next = s11_vb_reg;
            end
            default:
            begin
                or_next = s11_vb_reg; og_next = s11_pb_reg; ob_next = qb;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[12])
        begin
            s12_b_reg <= ob_next;
            s12_g_reg <= og_next;
            s12_r_reg <= or_next;
        end
    end

    assign m_tdata = {s12_r_reg, s12_g_reg, s12_b_reg};

endmodule

[rtl/core/hsbsca_checker.sv]
// ============================================================================
// hsbsca_checker
// Port-level assertions for the selective color adjust unit, bound to it.
// ============================================================================
module hsbsca_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [23:0]                    m_tdata,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [hsbsca_pkg::ADDR_W-1:0]  paddr,
    input logic [hsbsca_pkg::DATA_W-1:0]  pwdata,
    input logic [hsbsca_pkg::DATA_W-1:0]  prdata,
    input logic                           pready
);
    import hsbsca_pkg::*;

    logic cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] <= REG_MAGENTA);

    // stalled output transfer holds its pixel
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output pixel changed while stalled");

    // input is refused only when every stage is full and the output stalls
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input refused with room in the pipeline");

    // no output straight out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

    // a written register reads back on the same address
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr ##1 (paddr == $past(paddr)) |->
            prdata == DATA_W'($past(pwdata[ADJ_W-1:0])))
        else $error("register read back mismatch");

endmodule

bind hsb_selective_color_adjust_unit hsbsca_checker u_hsbsca_checker (.*);
